### hdl/fdws_pkg.sv
// ============================================================================
// Flip-dot wipe refresh scanner package
// Field widths, command codes and register map shared by the interfaces and
// the scanner.
// ============================================================================
package fdws_pkg;

    // Item field widths
    localparam int CMD_W      = 1;
    localparam int COL_IDX_W  = 7;
    localparam int DOTS_W     = 7;
    localparam int FLIP_COL_W = 7;
    localparam int FLIP_ROW_W = 3;

    // Request commands
    localparam logic [CMD_W-1:0] CMD_WRITE = 1'b0;
    localparam logic [CMD_W-1:0] CMD_TICK  = 1'b1;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 1;
    localparam logic [REG_IDX_W-1:0] REG_WIPE_DIRECTION = 1'b0;

    // Column wipe directions
    localparam logic DIR_LEFT_TO_RIGHT = 1'b0;
    localparam logic DIR_RIGHT_TO_LEFT = 1'b1;

    // One result as it sits in the output register
    typedef struct packed {
        logic                  flip_valid;
        logic [FLIP_COL_W-1:0] flip_column;
        logic [FLIP_ROW_W-1:0] flip_row;
        logic                  drive_high;
        logic                  panel_clean;
    } result_t;

endpackage

### hdl/fdws_if.sv
// ============================================================================
// Flip-dot wipe refresh scanner channels
// Valid/ready channels for incoming requests and outgoing flip results.
// ============================================================================
interface fdws_item_if;
    logic                           valid;
    logic                           ready;
    logic [fdws_pkg::CMD_W-1:0]     command;
    logic [fdws_pkg::COL_IDX_W-1:0] column_index;
    logic [fdws_pkg::DOTS_W-1:0]    column_dots;

    modport source (output valid, output command, output column_index,
                    output column_dots, input ready);
    modport sink   (input valid, input command, input column_index,
                    input column_dots, output ready);
endinterface

interface fdws_result_if;
    logic                            valid;
    logic                            ready;
    logic                            flip_valid;
    logic [fdws_pkg::FLIP_COL_W-1:0] flip_column;
    logic [fdws_pkg::FLIP_ROW_W-1:0] flip_row;
    logic                            drive_high;
    logic                            panel_clean;

    modport source (output valid, output flip_valid, output flip_column,
                    output flip_row, output drive_high, output panel_clean,
                    input ready);
    modport sink   (input valid, input flip_valid, input flip_column,
                    input flip_row, input drive_high, input panel_clean,
                    output ready);
endinterface

### hdl/flipdot_wipe_refresh_scanner.sv
// ============================================================================
// Flip-dot wipe refresh scanner
// Keeps the wanted and shown dot columns and hands out the next dot to flip.
// ============================================================================
// Usage:
//   item channel: a request is either a column write (command CMD_WRITE),
//   which replaces one wanted column and marks the panel dirty, or a tick
//   (CMD_TICK), which asks for the next dot to flip. Each tick yields exactly
//   one result on the result channel; writes yield none.
//   APB port: register 0 bit 0 is wipe_direction (0 left to right, 1 right
//   to left). Write it only while the block is idle.
// Sequencing:
//   A write reads the column entry, then writes it back. A tick on a clean
//   panel reports panel_clean without a scan. A tick on a dirty panel scans
//   from 1 to COLUMNS columns; the scan checks one column per cycle through
//   the single read port of the column memory. One request is in work at a
//   time.
// Reset:
//   All columns read as shown = all dots set, wanted = all clear, through a
//   per-column valid bit, so no clearing pass is needed. Dirty is clear.
// Stall:
//   A finished result waits in the output register; new writes are still
//   taken, and a tick scans but holds its result until that register frees.
// ============================================================================
module flipdot_wipe_refresh_scanner #(
    parameter int COLUMNS = 128,
    parameter int ROWS    = 7
) (
    input  logic                                clk,
    input  logic                                rst_n,
    fdws_item_if.sink                           item,
    fdws_result_if.source                       result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fdws_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [fdws_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [fdws_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int CW      = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int RW      = $clog2(ROWS + 1);
    localparam int MEM_W   = 2 * ROWS;
    localparam logic [CW-1:0]   LAST_COL   = CW'(COLUMNS - 1);
    localparam logic [ROWS-1:0] SHOWN_INIT = {ROWS{1'b1}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WRITE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic wipe_dir_reg;
    logic cfg_wr;
    logic [fdws_pkg::REG_IDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[fdws_pkg::APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Capture the direction bit on a completed write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wipe_dir_reg <= fdws_pkg::DIR_LEFT_TO_RIGHT;
        end
        else if (cfg_wr && cfg_idx == fdws_pkg::REG_WIPE_DIRECTION)
        begin
            wipe_dir_reg <= pwdata[0];
        end
    end

    // Read back the direction register
    always_comb
    begin
        prdata = '0;
        unique case (cfg_idx)
            fdws_pkg::REG_WIPE_DIRECTION: prdata[0] = wipe_dir_reg;
            default:                      prdata    = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    state_t                 state_reg,     state_next;
    logic                   dirty_reg,     dirty_next;
    logic [CW-1:0]          scan_col_reg,  scan_col_next;
    logic [RW-1:0]          scan_row_reg,  scan_row_next;
    logic [CW-1:0]          wr_col_reg,    wr_col_next;
    logic [ROWS-1:0]        wr_dots_reg,   wr_dots_next;
    fdws_pkg::result_t      res_reg,       res_next;
    fdws_pkg::result_t      out_reg,       out_next;
    logic                   out_valid_reg, out_valid_next;
    logic [COLUMNS-1:0]     vld_reg,       vld_next;
    logic                   vld_q_reg,     vld_q_next;

    // Column memory: {shown, wanted}
    logic                   ram_we;
    logic [CW-1:0]          ram_waddr;
    logic [MEM_W-1:0]       ram_wdata;
    logic                   ram_re;
    logic [CW-1:0]          ram_raddr;
    logic [MEM_W-1:0]       ram_rdata;

    fdws_ram #(
        .WIDTH (MEM_W),
        .DEPTH (COLUMNS)
    ) u_col_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic            item_acc;
    logic            slot_free;
    logic [CW-1:0]   first_col;
    logic            in_range;
    logic [ROWS-1:0] ent_shown;
    logic [ROWS-1:0] ent_wanted;
    logic [ROWS-1:0] row_ok;
    logic [ROWS-1:0] diff;
    logic            hit;
    logic [RW-1:0]   hit_row;
    logic [ROWS-1:0] hit_bit;
    logic            hit_new;
    logic            last_col;
    logic [CW-1:0]   adv_col;

    assign item.ready = (state_reg == ST_IDLE);
    assign item_acc   = item.valid && item.ready;
    assign slot_free  = !out_valid_reg || result.ready;
    assign first_col  = (wipe_dir_reg == fdws_pkg::DIR_RIGHT_TO_LEFT) ? LAST_COL : '0;
    assign in_range   = (32'(item.column_index) < COLUMNS);

    // Entry of the column just read; never-written columns take reset values
    assign ent_shown  = vld_q_reg ? ram_rdata[MEM_W-1:ROWS] : SHOWN_INIT;
    assign ent_wanted = vld_q_reg ? ram_rdata[ROWS-1:0]     : '0;

    // Find the lowest differing row at or above the scan row
    always_comb
    begin
        hit     = 1'b0;
        hit_row = '0;
        hit_bit = '0;
        hit_new = 1'b0;
        for (int i = 0; i < ROWS; i++)
        begin
            row_ok[i] = (RW'(i) >= scan_row_reg);
        end
        diff = (ent_shown ^ ent_wanted) & row_ok;
        for (int i = ROWS - 1; i >= 0; i--)
        begin
            if (diff[i])
            begin
                hit     = 1'b1;
                hit_row = RW'(i);
                hit_bit = ROWS'(1) << i;
                hit_new = ent_wanted[i];
            end
        end
    end

    // Next column in the current direction
    always_comb
    begin
        if (wipe_dir_reg == fdws_pkg::DIR_RIGHT_TO_LEFT)
        begin
            last_col = (scan_col_reg == '0);
            adv_col  = scan_col_reg - CW'(1);
        end
        else
        begin
            last_col = (scan_col_reg == LAST_COL);
            adv_col  = scan_col_reg + CW'(1);
        end
    end

    // Sequencer: decode requests, scan columns, write back, emit results
    always_comb
    begin
        state_next     = state_reg;
        dirty_next     = dirty_reg;
        scan_col_next  = scan_col_reg;
        scan_row_next  = scan_row_reg;
        wr_col_next    = wr_col_reg;
        wr_dots_next   = wr_dots_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        vld_next       = vld_reg;
        vld_q_next     = vld_q_reg;
        ram_we         = 1'b0;
        ram_waddr      = scan_col_reg;
        ram_wdata      = {ent_shown, ent_wanted};
        ram_re         = 1'b0;
        ram_raddr      = scan_col_reg;

        // Drop a result once the receiver takes it
        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_acc)
                begin
                    if (item.command == fdws_pkg::CMD_WRITE)
                    begin
                        if (in_range)
                        begin
                            if (!dirty_reg)
                            begin
                                scan_col_next = first_col;
                                scan_row_next = '0;
                            end
                            dirty_next   = 1'b1;
                            wr_col_next  = CW'(item.column_index);
                            wr_dots_next = ROWS'(item.column_dots);
                            ram_re       = 1'b1;
                            ram_raddr    = CW'(item.column_index);
                            state_next   = ST_WRITE;
                        end
                    end
                    else if (dirty_reg)
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = scan_col_reg;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        res_next             = '0;
                        res_next.panel_clean = 1'b1;
                        state_next           = ST_EMIT;
                    end
                end
            end

            ST_WRITE:
            begin
                // Replace the wanted half, keep the shown half
                ram_we             = 1'b1;
                ram_waddr          = wr_col_reg;
                ram_wdata          = {ent_shown, wr_dots_reg};
                vld_next[wr_col_reg] = 1'b1;
                state_next         = ST_IDLE;
            end

            ST_SCAN:
            begin
                if (hit)
                begin
                    ram_we                 = 1'b1;
                    ram_waddr              = scan_col_reg;
                    ram_wdata              = {ent_shown ^ hit_bit, ent_wanted};
                    vld_next[scan_col_reg] = 1'b1;
                    scan_row_next          = hit_row + RW'(1);
                    res_next.flip_valid    = 1'b1;
                    res_next.flip_column   = fdws_pkg::FLIP_COL_W'(scan_col_reg);
                    res_next.flip_row      = fdws_pkg::FLIP_ROW_W'(hit_row);
                    res_next.drive_high    = hit_new ^ ~hit_row[0];
                    res_next.panel_clean   = 1'b0;
                    state_next             = ST_EMIT;
                end
                else if (last_col)
                begin
                    dirty_next           = 1'b0;
                    scan_col_next        = first_col;
                    scan_row_next        = '0;
                    res_next             = '0;
                    res_next.panel_clean = 1'b1;
                    state_next           = ST_EMIT;
                end
                else
                begin
                    scan_col_next = adv_col;
                    scan_row_next = '0;
                    ram_re        = 1'b1;
                    ram_raddr     = adv_col;
                end
            end

            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Track validity of the entry being read
        if (ram_re)
        begin
            vld_q_next = vld_reg[ram_raddr];
        end
    end

    // Hold state, scan position, valid bits and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dirty_reg     <= 1'b0;
            scan_col_reg  <= '0;
            scan_row_reg  <= '0;
            wr_col_reg    <= '0;
            wr_dots_reg   <= '0;
            res_reg       <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
            vld_reg       <= '0;
            vld_q_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dirty_reg     <= dirty_next;
            scan_col_reg  <= scan_col_next;
            scan_row_reg  <= scan_row_next;
            wr_col_reg    <= wr_col_next;
            wr_dots_reg   <= wr_dots_next;
            res_reg       <= res_next;
            out_reg       <= out_next;
            out_valid_reg <= out_valid_next;
            vld_reg       <= vld_next;
            vld_q_reg     <= vld_q_next;
        end
    end

    // Drive the result channel
    assign result.valid       = out_valid_reg;
    assign result.flip_valid  = out_reg.flip_valid;
    assign result.flip_column = out_reg.flip_column;
    assign result.flip_row    = out_reg.flip_row;
    assign result.drive_high  = out_reg.drive_high;
    assign result.panel_clean = out_reg.panel_clean;

`ifndef SYNTHESIS
    // A scan only runs while a pass is pending
    a_scan_dirty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> dirty_reg)
        else $error("scan running with clean panel");

    // Memory write-back never overlaps a new request
    a_wb_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !item_acc)
        else $error("write-back overlaps an accepted request");

    // A pending flip leaves the scan row past the flipped dot
    a_flip_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && res_reg.flip_valid) |-> (scan_row_reg != '0))
        else $error("flip pending with scan row at zero");

    // A tick on a dirty panel starts a scan
    a_tick_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (item_acc && item.command == fdws_pkg::CMD_TICK && dirty_reg)
            |=> (state_reg == ST_SCAN))
        else $error("dirty tick did not start a scan");

    // A flip result never reports a clean panel
    a_flip_not_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.flip_valid) |-> !out_reg.panel_clean)
        else $error("flip result marked clean");
`endif

endmodule

### hdl/fdws_ram.sv
// ============================================================================
// Flip-dot wipe refresh scanner RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ============================================================================
module fdws_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 128
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
